// ===== rtl/core/sbfu_pkg.sv =====
// ----------------------------------------------------------------------------
// Seven-bit frame unpacker package
// Shared constants, codes and the job record passed from front to back.
// ----------------------------------------------------------------------------
package sbfu_pkg;

  localparam int FIELDS     = 8;
  localparam int PORTS      = 16;
  localparam int MAX_FRAME  = 128;
  localparam int VAL_W      = 32;
  localparam int FIDX_W     = (FIELDS > 1) ? $clog2(FIELDS) : 1;
  localparam int PORT_W     = 4;
  localparam int POS_W      = 11;

  localparam logic [1:0] KIND_REG  = 2'b11;
  localparam logic [1:0] KIND_DATA = 2'b10;

  typedef enum logic [2:0] {
    ST_FIELD      = 3'd0,
    ST_REGISTERED = 3'd1,
    ST_OVERFLOW   = 3'd2,
    ST_LEN_ERR    = 3'd3,
    ST_SUM_ERR    = 3'd4,
    ST_UNKNOWN    = 3'd5
  } status_t;

  typedef enum logic {
    PH_HUNT = 1'b0,
    PH_BODY = 1'b1
  } phase_t;

  typedef struct packed {
    status_t                        status;
    logic [PORT_W-1:0]              port;
    logic [FIELDS-1:0][VAL_W-1:0]   vals;
    logic [FIELDS-1:0][6:0]         cnts;
    logic [FIELDS-1:0][6:0]         lens;
    logic [FIELDS-1:0][6:0]         types;
  } job_t;

endpackage

// ===== rtl/core/seven_bit_frame_field_unpacker.sv =====
// A received byte is taken back to back, while the job queue has room.
// A result-producing byte's job goes through the queue, then the output register.
// A good data frame tail yields eight beats, one per cycle while popped.
// Reset clears all control state; the port tables read as zero until written.
// ----------------------------------------------------------------------------
// Seven-bit frame field unpacker
// Top level: byte queue interface, configuration port, front, queue and back.
// ----------------------------------------------------------------------------
module seven_bit_frame_field_unpacker
  import sbfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_rx_byte,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  out_status,
  output logic [3:0]  out_port_id,
  output logic [2:0]  out_field_index,
  output logic [6:0]  out_field_type,
  output logic [31:0] out_field_value,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [6:0] signed_code_r;
  logic       q_full, q_empty, job_valid, job_pop;
  job_t       front_job, head_job;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {25'b0, signed_code_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signed_code_r <= 7'd3;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      signed_code_r <= pwdata[6:0];
    end
  end

  assign full = q_full;

  sbfu_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_valid(push && !q_full),
    .rx_byte   (in_rx_byte),
    .job_valid (job_valid),
    .job       (front_job)
  );

  sbfu_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .wr_en  (job_valid),
    .wr_job (front_job),
    .rd_en  (job_pop),
    .rd_job (head_job),
    .q_full (q_full),
    .q_empty(q_empty)
  );

  sbfu_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .job_valid  (!q_empty),
    .job        (head_job),
    .signed_code(signed_code_r),
    .job_pop    (job_pop),
    .pop        (pop),
    .empty      (empty),
    .status     (out_status),
    .port_id    (out_port_id),
    .field_index(out_field_index),
    .field_type (out_field_type),
    .field_value(out_field_value),
    .last       (out_last)
  );

endmodule

// ===== rtl/core/sbfu_front.sv =====
// ----------------------------------------------------------------------------
// Frame parser front end
// Hunts for frames, checks length and checksum, unpacks payload bits into
// staged fields, keeps the per-port field tables and issues one job per
// result-producing byte.
// ----------------------------------------------------------------------------
module sbfu_front
  import sbfu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       byte_valid,
  input  logic [7:0] rx_byte,
  output logic       job_valid,
  output job_t       job
);

  phase_t                       phase_r, phase_nxt;
  logic [1:0]                   kind_r, kind_nxt;
  logic [PORT_W-1:0]            port_r, port_nxt;
  logic [6:0]                   bcnt_r, bcnt_nxt;
  logic [20:0]                  sum_r, sum_nxt;
  logic [2:0][6:0]              hb_r, hb_nxt;
  logic [1:0]                   hfill_r, hfill_nxt;
  logic [6:0]                   ppos_r, ppos_nxt;
  logic [9:0]                   bpos_r, bpos_nxt;
  logic [FIELDS-1:0][VAL_W-1:0] sv_r, sv_nxt, sv_unp;
  logic [FIELDS-1:0][6:0]       sc_r, sc_nxt, sc_unp;
  logic [FIELDS-1:0][13:0]      sp_r, sp_nxt;

  logic [FIELDS-1:0][6:0]       type_tab_r [PORTS];
  logic [FIELDS-1:0][6:0]       len_tab_r  [PORTS];
  logic [PORTS-1:0]             rowv_r;
  logic [FIELDS-1:0][6:0]       row_len, row_type, new_len, new_type;
  logic                         tab_we;
  logic [FIELDS-1:0][POS_W-1:0] start_r, end_r, start_nxt, end_nxt;

  always_comb begin
    row_len  = rowv_r[port_r] ? len_tab_r[port_r]  : '0;
    row_type = rowv_r[port_r] ? type_tab_r[port_r] : '0;
  end

  always_comb begin
    logic [POS_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < FIELDS; i++) begin
      start_nxt[i] = acc;
      acc          = acc + POS_W'(row_len[i]);
      end_nxt[i]   = acc;
    end
  end

  always_comb begin
    logic [POS_W-1:0] bp, bp7, lo, hi;
    logic [2:0]       n, off;
    logic [6:0]       tmp, sub;
    logic [7:0]       csum;
    bp  = POS_W'(bpos_r);
    bp7 = bp + POS_W'(7);
    for (int i = 0; i < FIELDS; i++) begin
      lo   = (start_r[i] > bp) ? start_r[i] : bp;
      hi   = (end_r[i] < bp7) ? end_r[i] : bp7;
      n    = (hi > lo) ? 3'(hi - lo) : 3'd0;
      off  = 3'(lo - bp);
      tmp  = 7'(hb_r[0] << off);
      sub  = tmp >> (3'd7 - n);
      sv_unp[i] = (n == 3'd0) ? sv_r[i] : (VAL_W'(sv_r[i] << n) | VAL_W'(sub));
      csum = {1'b0, sc_r[i]} + {5'b0, n};
      sc_unp[i] = csum[7] ? 7'd127 : csum[6:0];
    end
  end

  always_comb begin
    logic [7:0]              flen;
    logic [20:0]             csum;
    logic [5:0]              pi;
    logic [FIDX_W-1:0]       pidx;
    phase_nxt = phase_r;
    kind_nxt  = kind_r;
    port_nxt  = port_r;
    bcnt_nxt  = bcnt_r;
    sum_nxt   = sum_r;
    hb_nxt    = hb_r;
    hfill_nxt = hfill_r;
    ppos_nxt  = ppos_r;
    bpos_nxt  = bpos_r;
    sv_nxt    = sv_r;
    sc_nxt    = sc_r;
    sp_nxt    = sp_r;
    job_valid = 1'b0;
    job       = '0;
    job.port  = port_r;
    tab_we    = 1'b0;
    flen      = {1'b0, bcnt_r} + 8'd1;
    csum      = {hb_r[0], hb_r[1], hb_r[2]};
    pi        = ppos_r[6:1];
    pidx      = FIDX_W'(pi);
    for (int i = 0; i < FIELDS; i++) begin
      new_type[i] = ({1'b0, ppos_r} >= 8'(2 * i + 1)) ? sp_r[i][13:7] : row_type[i];
      new_len[i]  = ({1'b0, ppos_r} >= 8'(2 * i + 2)) ? sp_r[i][6:0]  : row_len[i];
    end
    if (byte_valid) begin
      if (phase_r == PH_HUNT) begin
        if (rx_byte[7]) begin
          phase_nxt = PH_BODY;
          kind_nxt  = rx_byte[7:6];
          port_nxt  = rx_byte[3:0];
          bcnt_nxt  = 7'd1;
          sum_nxt   = '0;
          hb_nxt    = '0;
          hfill_nxt = '0;
          ppos_nxt  = '0;
          bpos_nxt  = '0;
          sv_nxt    = '0;
          sc_nxt    = '0;
          sp_nxt    = '0;
        end
      end else if (rx_byte[7]) begin
        phase_nxt = PH_HUNT;
        job_valid = 1'b1;
        priority if (flen < 8'd5) begin
          job.status = ST_LEN_ERR;
        end else if (csum != sum_r) begin
          job.status = ST_SUM_ERR;
        end else if (rx_byte[6:0] != flen[6:0]) begin
          job.status = ST_LEN_ERR;
        end else if (kind_r == KIND_REG) begin
          job.status = ST_REGISTERED;
          tab_we     = 1'b1;
        end else begin
          job.status = ST_FIELD;
          job.vals   = sv_r;
          job.cnts   = sc_r;
          job.lens   = row_len;
          job.types  = row_type;
        end
      end else if (32'(bcnt_r) + 32'd3 > 32'(MAX_FRAME)) begin
        phase_nxt  = PH_HUNT;
        job_valid  = 1'b1;
        job.status = ST_OVERFLOW;
      end else begin
        bcnt_nxt = bcnt_r + 7'd1;
        if (hfill_r == 2'd3) begin
          sum_nxt   = sum_r + 21'(hb_r[0]);
          hb_nxt[0] = hb_r[1];
          hb_nxt[1] = hb_r[2];
          hb_nxt[2] = rx_byte[6:0];
          if (ppos_r != 7'd127) begin
            ppos_nxt = ppos_r + 7'd1;
          end
          if (kind_r == KIND_REG) begin
            if (32'(pi) < FIELDS) begin
              if (!ppos_r[0]) begin
                sp_nxt[pidx][13:7] = hb_r[0];
              end else begin
                sp_nxt[pidx][6:0] = hb_r[0];
              end
            end
          end else if (kind_r == KIND_DATA) begin
            sv_nxt   = sv_unp;
            sc_nxt   = sc_unp;
            bpos_nxt = (bpos_r > 10'd1016) ? 10'd1023 : bpos_r + 10'd7;
          end
        end else begin
          hb_nxt[hfill_r] = rx_byte[6:0];
          hfill_nxt       = hfill_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      kind_r  <= '0;
      port_r  <= '0;
      bcnt_r  <= '0;
      sum_r   <= '0;
      hb_r    <= '0;
      hfill_r <= '0;
      ppos_r  <= '0;
      bpos_r  <= '0;
      sv_r    <= '0;
      sc_r    <= '0;
      sp_r    <= '0;
      rowv_r  <= '0;
    end else begin
      phase_r <= phase_nxt;
      kind_r  <= kind_nxt;
      port_r  <= port_nxt;
      bcnt_r  <= bcnt_nxt;
      sum_r   <= sum_nxt;
      hb_r    <= hb_nxt;
      hfill_r <= hfill_nxt;
      ppos_r  <= ppos_nxt;
      bpos_r  <= bpos_nxt;
      sv_r    <= sv_nxt;
      sc_r    <= sc_nxt;
      sp_r    <= sp_nxt;
      if (tab_we) begin
        rowv_r[port_r] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    start_r <= start_nxt;
    end_r   <= end_nxt;
    if (tab_we) begin
      type_tab_r[port_r] <= new_type;
      len_tab_r[port_r]  <= new_len;
    end
  end

endmodule

// ===== rtl/core/sbfu_queue.sv =====
// ----------------------------------------------------------------------------
// Job queue
// Two-entry queue that decouples the frame parser from the result emitter.
// ----------------------------------------------------------------------------
module sbfu_queue
  import sbfu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  job_t wr_job,
  input  logic rd_en,
  output job_t rd_job,
  output logic q_full,
  output logic q_empty
);

  job_t       mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign q_full  = (cnt_r == 2'd2);
  assign q_empty = (cnt_r == 2'd0);
  assign rd_job  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= ~wp_r;
      end
      if (rd_en) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_job;
    end
  end

endmodule

// ===== rtl/core/sbfu_back.sv =====
// ----------------------------------------------------------------------------
// Result emitter
// Expands each job into result beats, pads short fields and sign-extends
// signed fields, one beat per cycle into the output register while it is empty or popped.
// ----------------------------------------------------------------------------
module sbfu_back
  import sbfu_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  input  job_t        job,
  input  logic [6:0]  signed_code,
  output logic        job_pop,
  input  logic        pop,
  output logic        empty,
  output logic [2:0]  status,
  output logic [3:0]  port_id,
  output logic [2:0]  field_index,
  output logic [6:0]  field_type,
  output logic [31:0] field_value,
  output logic        last
);

  logic              ov_r, ov_nxt;
  logic [FIDX_W-1:0] k_r, k_nxt;
  logic [2:0]        st_r, st_nxt;
  logic [3:0]        port_r, port_nxt;
  logic [2:0]        idx_r, idx_nxt;
  logic [6:0]        ty_r, ty_nxt;
  logic [31:0]       val_r, val_nxt;
  logic              last_r, last_nxt;

  always_comb begin
    logic [6:0]  flen, cnt;
    logic [31:0] v;
    logic        adv;
    ov_nxt   = ov_r;
    k_nxt    = k_r;
    st_nxt   = st_r;
    port_nxt = port_r;
    idx_nxt  = idx_r;
    ty_nxt   = ty_r;
    val_nxt  = val_r;
    last_nxt = last_r;
    job_pop  = 1'b0;
    flen     = job.lens[k_r];
    cnt      = job.cnts[k_r];
    v        = job.vals[k_r];
    if (cnt < flen) begin
      v = v << (flen - cnt);
    end
    if (job.types[k_r] == signed_code && flen != 7'd0 && flen < 7'(VAL_W)) begin
      if (v[5'(flen - 7'd1)]) begin
        v = v | ~((32'd1 << flen) - 32'd1);
      end
    end
    adv = !ov_r || pop;
    if (adv) begin
      ov_nxt = 1'b0;
      if (job_valid) begin
        ov_nxt   = 1'b1;
        st_nxt   = job.status;
        port_nxt = job.port;
        if (job.status != ST_FIELD) begin
          idx_nxt  = '0;
          ty_nxt   = '0;
          val_nxt  = '0;
          last_nxt = 1'b1;
          job_pop  = 1'b1;
          k_nxt    = '0;
        end else begin
          idx_nxt  = 3'(k_r);
          ty_nxt   = job.types[k_r];
          val_nxt  = v;
          last_nxt = (32'(k_r) == FIELDS - 1);
          job_pop  = last_nxt;
          k_nxt    = last_nxt ? '0 : k_r + FIDX_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
      k_r  <= '0;
    end else begin
      ov_r <= ov_nxt;
      k_r  <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r   <= st_nxt;
    port_r <= port_nxt;
    idx_r  <= idx_nxt;
    ty_r   <= ty_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  assign empty       = ~ov_r;
  assign status      = st_r;
  assign port_id     = port_r;
  assign field_index = idx_r;
  assign field_type  = ty_r;
  assign field_value = val_r;
  assign last        = last_r;

endmodule
